// File: rtl/dtd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the dual trigger hysteresis debouncer.
// No dependencies; used by dtd_csr, dtd_chan and the top level.
package dtd_pkg;

   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_CLOSE_THR    = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_RELEASE_THR  = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_DEBOUNCE     = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TIMEOUT      = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_REQUIRE_HOME = 3'd4;

   localparam logic [CSR_DATA_BITS-1:0] CLOSE_THR_RESET   = 16'd49151;
   localparam logic [CSR_DATA_BITS-1:0] RELEASE_THR_RESET = 16'd16384;
   localparam logic [CSR_DATA_BITS-1:0] DEBOUNCE_RESET    = 16'd8;
   localparam logic [CSR_DATA_BITS-1:0] TIMEOUT_RESET     = 16'd18;
   localparam logic                     REQUIRE_HOME_RESET = 1'b1;

   // result beat: five flags, padded to a byte
   localparam int RSP_FIELD_BITS = 5;
   localparam int RSP_DATA_BITS  = 8;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] close_thr;
      logic [CSR_DATA_BITS-1:0] release_thr;
      logic [CSR_DATA_BITS-1:0] debounce_ticks;
      logic [CSR_DATA_BITS-1:0] timeout_ticks;
      logic                     require_home;
   } cfg_type;

   // per-tick control from the top level to each channel
   typedef struct packed {
      logic step;        // a tick is accepted this cycle
      logic stale;       // hold states, ages keep running
      logic home_clear;  // force channel back to its reset state
   } chan_ctrl_type;

endpackage

// File: rtl/dtd_csr.sv
`timescale 1ns / 1ps
// Configuration register bank for the debouncer.
// Depends on dtd_pkg for register indexes, reset values and cfg_type.
module dtd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [dtd_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [dtd_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output dtd_pkg::cfg_type                    cfg
);

   dtd_pkg::cfg_type cfg_ff;
   dtd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            dtd_pkg::CSR_CLOSE_THR:    cfg_in.close_thr      = csr_wdata;
            dtd_pkg::CSR_RELEASE_THR:  cfg_in.release_thr    = csr_wdata;
            dtd_pkg::CSR_DEBOUNCE:     cfg_in.debounce_ticks = csr_wdata;
            dtd_pkg::CSR_TIMEOUT:      cfg_in.timeout_ticks  = csr_wdata;
            dtd_pkg::CSR_REQUIRE_HOME: cfg_in.require_home   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.close_thr      <= dtd_pkg::CLOSE_THR_RESET;
         cfg_ff.release_thr    <= dtd_pkg::RELEASE_THR_RESET;
         cfg_ff.debounce_ticks <= dtd_pkg::DEBOUNCE_RESET;
         cfg_ff.timeout_ticks  <= dtd_pkg::TIMEOUT_RESET;
         cfg_ff.require_home   <= dtd_pkg::REQUIRE_HOME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/dtd_chan.sv
`timescale 1ns / 1ps
// One trigger channel: hysteresis threshold followed by a tick debounce.
// Depends on dtd_pkg for cfg_type and chan_ctrl_type.
module dtd_chan #(
   parameter int LEVEL_BITS = 16,
   parameter int AGE_BITS   = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dtd_pkg::chan_ctrl_type     ctrl,
   input  dtd_pkg::cfg_type           cfg,
   input  logic [LEVEL_BITS-1:0]      level,
   output logic                       stable,
   output logic                       stable_next
);

   localparam int CMP_BITS = (AGE_BITS > dtd_pkg::CSR_DATA_BITS) ?
                             AGE_BITS : dtd_pkg::CSR_DATA_BITS;
   localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

   logic                stable_ff, stable_in;
   logic                cand_ff, cand_in;
   logic [AGE_BITS-1:0] age_ff, age_in;

   logic [LEVEL_BITS-1:0] close_lvl;
   logic [LEVEL_BITS-1:0] release_lvl;
   logic [AGE_BITS-1:0]   age_inc;
   logic                  req;

   // thresholds are cut or widened to the level width
   assign close_lvl   = LEVEL_BITS'(cfg.close_thr);
   assign release_lvl = LEVEL_BITS'(cfg.release_thr);
   assign age_inc     = (age_ff == AGE_MAX) ? age_ff : age_ff + 1'b1;
   assign req         = stable_ff ? (level > release_lvl) : (level >= close_lvl);

   always_comb begin
      stable_in = stable_ff;
      cand_in   = cand_ff;
      age_in    = age_ff;
      if (ctrl.step) begin
         if (ctrl.stale) begin
            age_in = age_inc;
         end else if (ctrl.home_clear) begin
            stable_in = 1'b0;
            cand_in   = 1'b0;
            age_in    = AGE_MAX;
         end else begin
            if (req != cand_ff) begin
               cand_in = req;
               age_in  = '0;
            end else begin
               age_in  = age_inc;
            end
            if (cand_in != stable_ff &&
                CMP_BITS'(age_in) >= CMP_BITS'(cfg.debounce_ticks)) begin
               stable_in = cand_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= 1'b0;
         cand_ff   <= 1'b0;
         age_ff    <= AGE_MAX;
      end else begin
         stable_ff <= stable_in;
         cand_ff   <= cand_in;
         age_ff    <= age_in;
      end
   end

   assign stable      = stable_ff;
   assign stable_next = stable_in;

endmodule

// File: rtl/dual_trigger_hysteresis_debouncer.sv
`timescale 1ns / 1ps
// Dual trigger debouncer: each req beat is one publish tick, optionally with
// a new pair of Q0.LEVEL_BITS trigger levels (req_tuser = 1) and the homing
// status. Both channels apply a close/release hysteresis and a tick debounce;
// stale samples hold the states; require_home forces an unhomed block open.
// Every req beat yields exactly one rsp beat. One tick is taken per clock: the
// state update is a single compare-and-count pass, and results sit in a
// two-entry output buffer, so req_tready only drops when both entries wait.
// Depends on dtd_pkg, dtd_csr and dtd_chan.
module dual_trigger_hysteresis_debouncer #(
   parameter int LEVEL_BITS = 16,
   parameter int AGE_BITS   = 16,
   localparam int REQ_DATA_BITS = ((2 * LEVEL_BITS + 1 + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // left_value, right_value, homing done flag, zero padding
   input  logic [REQ_DATA_BITS-1:0]            req_tdata,
   // sample_present
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // left_closed, right_closed, input_stale, left_changed, right_changed, pad
   output logic [dtd_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                csr_we,
   input  logic [dtd_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [dtd_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int CMP_BITS = (AGE_BITS > dtd_pkg::CSR_DATA_BITS) ?
                             AGE_BITS : dtd_pkg::CSR_DATA_BITS;
   localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

   dtd_pkg::cfg_type       cfg;
   dtd_pkg::chan_ctrl_type ctrl;

   logic                  in_take, out_take;
   logic                  present, home;
   logic [LEVEL_BITS-1:0] left_value, right_value;

   logic [LEVEL_BITS-1:0] held_left_ff, held_left_in;
   logic [LEVEL_BITS-1:0] held_right_ff, held_right_in;
   logic                  seen_ff, seen_in;
   logic [AGE_BITS-1:0]   sample_age_ff, sample_age_in;
   logic                  fresh;

   logic left_stable, left_next, right_stable, right_next;
   logic [dtd_pkg::RSP_DATA_BITS-1:0] result;

   logic                              main_valid_ff, main_valid_in;
   logic                              skid_valid_ff, skid_valid_in;
   logic [dtd_pkg::RSP_DATA_BITS-1:0] main_data_ff, main_data_in;
   logic [dtd_pkg::RSP_DATA_BITS-1:0] skid_data_ff, skid_data_in;

   assign present     = req_tuser;
   assign left_value  = req_tdata[LEVEL_BITS-1:0];
   assign right_value = req_tdata[2*LEVEL_BITS-1:LEVEL_BITS];
   assign home        = req_tdata[2*LEVEL_BITS];

   assign req_tready = ~skid_valid_ff;
   assign in_take    = req_tvalid & req_tready;
   assign out_take   = rsp_tvalid & rsp_tready;

   dtd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sample latch and age
   always_comb begin
      held_left_in  = held_left_ff;
      held_right_in = held_right_ff;
      seen_in       = seen_ff;
      sample_age_in = sample_age_ff;
      if (in_take) begin
         if (present) begin
            held_left_in  = left_value;
            held_right_in = right_value;
            seen_in       = 1'b1;
            sample_age_in = '0;
         end else if (sample_age_ff != AGE_MAX) begin
            sample_age_in = sample_age_ff + 1'b1;
         end
      end
   end

   assign fresh = seen_in && (CMP_BITS'(sample_age_in) <= CMP_BITS'(cfg.timeout_ticks));

   always_comb begin
      ctrl.step       = in_take;
      ctrl.stale      = ~fresh;
      ctrl.home_clear = cfg.require_home & ~home;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_left_ff  <= '0;
         held_right_ff <= '0;
         seen_ff       <= 1'b0;
         sample_age_ff <= '0;
      end else begin
         held_left_ff  <= held_left_in;
         held_right_ff <= held_right_in;
         seen_ff       <= seen_in;
         sample_age_ff <= sample_age_in;
      end
   end

   dtd_chan #(.LEVEL_BITS(LEVEL_BITS), .AGE_BITS(AGE_BITS)) u_left (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .cfg         (cfg),
      .level       (held_left_in),
      .stable      (left_stable),
      .stable_next (left_next)
   );

   dtd_chan #(.LEVEL_BITS(LEVEL_BITS), .AGE_BITS(AGE_BITS)) u_right (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .cfg         (cfg),
      .level       (held_right_in),
      .stable      (right_stable),
      .stable_next (right_next)
   );

   assign result = {{(dtd_pkg::RSP_DATA_BITS - dtd_pkg::RSP_FIELD_BITS){1'b0}},
                    right_next ^ right_stable,
                    left_next ^ left_stable,
                    ~fresh,
                    right_next,
                    left_next};

   // two-entry result buffer: main drives the port, skid catches a stalled beat
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (out_take) begin
         if (skid_valid_ff) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_take;
            main_data_in  = result;
         end
      end else if (in_take) begin
         if (!main_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = main_data_ff;

   // skid entry never holds a beat ahead of an empty main entry
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      !skid_valid_ff || main_valid_ff)
      else $error("skid entry valid while main entry empty");

   // unhomed fresh tick with require_home set forces both channels open
   a_home_clear: assert property (@(posedge clock) disable iff (reset)
      (in_take && fresh && cfg.require_home && !home) |=> (!left_stable && !right_stable))
      else $error("home gate did not clear channels");

   // stale tick holds both stable states
   a_stale_hold: assert property (@(posedge clock) disable iff (reset)
      (in_take && !fresh) |=> ($stable(left_stable) && $stable(right_stable)))
      else $error("stable state moved on a stale tick");

endmodule
